FILE: src/read_quality_filter_kmer_extract_unit_defines.svh
// Assertion macros shared by the checker files of the k-mer extract unit.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n
// in the scope where it is used.
`ifndef READ_QUALITY_FILTER_KMER_EXTRACT_UNIT_DEFINES_SVH
`define READ_QUALITY_FILTER_KMER_EXTRACT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RQF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rqf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqf_pkg;

    // Default sizes of the block.
    localparam int MAX_CHUNK_LEN_DEF = 256;
    localparam int MAX_KMER_LEN_DEF  = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LEN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_STRAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_QUAL_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_QUAL_MIN   = 3'd4;

    localparam logic [5:0] KMER_LEN_RST      = 6'd25;
    localparam logic [8:0] CHUNK_LEN_RST     = 9'd100;
    localparam logic       REVERSE_RST       = 1'b0;
    localparam logic [6:0] BASE_QUAL_MIN_RST = 7'd20;
    localparam logic [6:0] AVG_QUAL_MIN_RST  = 7'd30;

    // Field widths.
    localparam int KMER_CODE_W = 64;
    localparam int QUAL_SUM_W  = 15;

    // ASCII codes of the base letters and the quality offset.
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_N_UP = 8'h4E;
    localparam logic [7:0] CH_N_LO = 8'h6E;
    localparam logic [7:0] QUAL_OFFSET = 8'd33;

    // 2-bit base codes.
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // Pseudo-random code source for unknown letters.
    localparam logic [15:0] LFSR_RST  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [5:0] kmer_len;
        logic [8:0] chunk_len;
        logic       reverse_strand;
        logic [6:0] base_qual_min;
        logic [6:0] avg_qual_min;
    } t_cfg;

    // One classified base, as the front part hands it to the back part.
    typedef struct packed {
        logic [1:0] code;
        logic       is_n;
        logic       low_qual;
        logic [7:0] phred;
        logic       read_end;
    } t_class;

endpackage

`default_nettype wire

FILE: src/rqf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rqf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic [7:0] qual_char;
    logic       read_end;

    modport source (output valid, output base_char, output qual_char, output read_end,
                    input ready);
    modport sink   (input valid, input base_char, input qual_char, input read_end,
                    output ready);
endinterface

`default_nettype wire

FILE: src/rqf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rqf_out_if;
    logic        valid;
    logic        ready;
    logic        kmer_valid;
    logic [63:0] kmer_code;
    logic        chunk_done;
    logic        chunk_pass;
    logic        chunk_dropped;

    modport source (output valid, output kmer_valid, output kmer_code, output chunk_done,
                    output chunk_pass, output chunk_dropped, input ready);
    modport sink   (input valid, input kmer_valid, input kmer_code, input chunk_done,
                    input chunk_pass, input chunk_dropped, output ready);
endinterface

`default_nettype wire

FILE: src/rqf_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes each accepted base into its 2-bit code and quality flags.
module rqf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rqf_in_if.sink             i_in,
    input  rqf_pkg::t_cfg      i_cfg,
    input  wire logic          i_space,
    output logic               o_push,
    output rqf_pkg::t_class    o_item
);

    logic [15:0] r_lfsr;
    logic [15:0] n_lfsr;
    logic [15:0] lfsr_step;
    logic        accept;
    logic        known;
    logic [1:0]  known_code;
    logic [8:0]  qual_floor;

    assign i_in.ready = i_space;
    assign accept     = i_in.valid && i_space;
    assign o_push     = accept;

    // One Galois step; it only advances for letters other than ACGT.
    assign lfsr_step = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? rqf_pkg::LFSR_TAPS : 16'h0000);

    always_comb begin
        known      = 1'b1;
        known_code = rqf_pkg::CODE_A;
        case (i_in.base_char)
            rqf_pkg::CH_A_UP, rqf_pkg::CH_A_LO: known_code = rqf_pkg::CODE_A;
            rqf_pkg::CH_C_UP, rqf_pkg::CH_C_LO: known_code = rqf_pkg::CODE_C;
            rqf_pkg::CH_G_UP, rqf_pkg::CH_G_LO: known_code = rqf_pkg::CODE_G;
            rqf_pkg::CH_T_UP, rqf_pkg::CH_T_LO: known_code = rqf_pkg::CODE_T;
            default: known = 1'b0;
        endcase
    end

    assign n_lfsr     = (accept && !known) ? lfsr_step : r_lfsr;
    assign qual_floor = {1'b0, rqf_pkg::QUAL_OFFSET} + {2'b00, i_cfg.base_qual_min};

    always_comb begin
        o_item.code     = known ? known_code : lfsr_step[1:0];
        o_item.is_n     = (i_in.base_char == rqf_pkg::CH_N_UP) ||
                          (i_in.base_char == rqf_pkg::CH_N_LO);
        o_item.low_qual = {1'b0, i_in.qual_char} < qual_floor;
        o_item.phred    = i_in.qual_char - rqf_pkg::QUAL_OFFSET;
        o_item.read_end = i_in.read_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= rqf_pkg::LFSR_RST;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

`default_nettype wire

FILE: src/rqf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small FIFO of classified bases between the front and back parts.
module rqf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rqf_pkg::t_class    i_item,
    output logic               o_space,
    output logic               o_valid,
    output rqf_pkg::t_class    o_item,
    input  wire logic          i_pop
);

    localparam int Depth = rqf_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    rqf_pkg::t_class r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] n_wr;
    logic [PtrW-1:0] n_rd;
    logic [CntW-1:0] n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_space = r_cnt != CntW'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: src/rqf_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Chunk state: rolling k-mer, quality sum, fail flag and position.
// Builds the result of each base into the output register.
module rqf_back #(
    parameter int MAX_CHUNK_LEN = rqf_pkg::MAX_CHUNK_LEN_DEF,
    parameter int MAX_KMER_LEN  = rqf_pkg::MAX_KMER_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  rqf_pkg::t_cfg      i_cfg,
    input  wire logic          i_valid,
    input  rqf_pkg::t_class    i_item,
    output logic               o_pop,
    rqf_out_if.source          o_out
);

    localparam int KW    = 2 * MAX_KMER_LEN;
    localparam int LenW  = $clog2(MAX_CHUNK_LEN + 1);
    localparam int VCmpW = (LenW > 6) ? LenW : 6;
    localparam int ThrW  = LenW + 7;
    localparam int SW    = rqf_pkg::QUAL_SUM_W;
    localparam int CmpW  = (ThrW > SW) ? ThrW : SW;

    logic [LenW-1:0] r_pos;
    logic [KW-1:0]   r_kmer;
    logic [SW-1:0]   r_sum;
    logic            r_bad;
    logic            r_out_valid;
    logic            r_kmer_valid;
    logic [63:0]     r_kmer_code;
    logic            r_done;
    logic            r_pass;
    logic            r_dropped;

    logic [5:0]      keff;
    logic [LenW-1:0] len_eff;
    logic [KW-1:0]   mask;
    logic [6:0]      top_shift;
    logic [KW-1:0]   n_kmer;
    logic            n_bad;
    logic [SW:0]     sum_wide;
    logic [SW-1:0]   n_sum;
    logic [LenW-1:0] pos1;
    logic [ThrW-1:0] thr;
    logic            kvalid;
    logic            done;
    logic            pass;
    logic            dropped;
    logic            emit;

    always_comb begin
        if (i_cfg.kmer_len == '0) begin
            keff = 6'd1;
        end else if (int'(i_cfg.kmer_len) > MAX_KMER_LEN) begin
            keff = 6'(MAX_KMER_LEN);
        end else begin
            keff = i_cfg.kmer_len;
        end
        if (i_cfg.chunk_len == '0) begin
            len_eff = LenW'(1);
        end else if (int'(i_cfg.chunk_len) > MAX_CHUNK_LEN) begin
            len_eff = LenW'(MAX_CHUNK_LEN);
        end else begin
            len_eff = LenW'(i_cfg.chunk_len);
        end
    end

    always_comb begin
        for (int i = 0; i < KW; i++) begin
            mask[i] = i < 2 * int'(keff);
        end
    end

    assign top_shift = {keff, 1'b0} - 7'd2;

    always_comb begin
        if (i_cfg.reverse_strand) begin
            n_kmer = ((r_kmer >> 2) | (KW'(~i_item.code) << top_shift)) & mask;
        end else begin
            n_kmer = ((r_kmer << 2) | KW'(i_item.code)) & mask;
        end
    end

    assign n_bad    = r_bad || i_item.is_n || i_item.low_qual;
    assign sum_wide = {1'b0, r_sum} + (SW + 1)'(i_item.phred);

    always_comb begin
        if (i_item.low_qual) begin
            n_sum = r_sum;
        end else if (sum_wide[SW]) begin
            n_sum = '1;
        end else begin
            n_sum = sum_wide[SW-1:0];
        end
    end

    assign pos1    = r_pos + 1'b1;
    assign thr     = ThrW'(len_eff) * ThrW'(i_cfg.avg_qual_min);
    assign kvalid  = VCmpW'(pos1) >= VCmpW'(keff);
    assign done    = pos1 >= len_eff;
    assign pass    = !n_bad && (CmpW'(n_sum) >= CmpW'(thr));
    assign dropped = !done && i_item.read_end;
    assign emit    = kvalid || done || dropped;

    // The next base is taken whenever the output register is free or being emptied.
    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_kmer      <= '0;
            r_sum       <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_out_valid && !o_out.ready) || (o_pop && emit);
            if (o_pop) begin
                if (done || dropped) begin
                    r_pos  <= '0;
                    r_kmer <= '0;
                    r_sum  <= '0;
                    r_bad  <= 1'b0;
                end else begin
                    r_pos  <= pos1;
                    r_kmer <= n_kmer;
                    r_sum  <= n_sum;
                    r_bad  <= n_bad;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kmer_valid <= kvalid;
            r_kmer_code  <= kvalid ? 64'(n_kmer) : 64'd0;
            r_done       <= done;
            r_pass       <= done && pass;
            r_dropped    <= dropped;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kmer_valid    = r_kmer_valid;
    assign o_out.kmer_code     = r_kmer_code;
    assign o_out.chunk_done    = r_done;
    assign o_out.chunk_pass    = r_pass;
    assign o_out.chunk_dropped = r_dropped;

endmodule

`default_nettype wire

FILE: src/read_quality_filter_kmer_extract_unit.sv
// Quality-filtered k-mer extractor. Bases of sequencing reads enter one item per cycle on
// i_in_ch while it is ready, each with its ASCII quality character and an end-of-read
// mark. Every raw read is cut into chunks of chunk_len bases; a rolling 2-bit k-mer (A=0,
// C=1, G=2, T=3, forward or reverse complement) is emitted from the kmer_len-th base of a
// chunk on, and the last base of a complete chunk carries a pass/fail verdict. A chunk
// fails on any N base, on any Phred quality below base_qual_min, or when its quality sum
// is below chunk_len * avg_qual_min. When a read ends inside an incomplete chunk, the item
// of that base has chunk_dropped set and the k-mers of that chunk should be discarded.
// Bases that make no result (before the first full k-mer) emit no item on o_out_ch. The
// unit takes one base per cycle sustained while o_out_ch is not stalled. An accepted base
// is decoded combinationally, written into the queue and then processed into the output
// register, which presents its result on o_out_ch. The back part's chunk state update sets
// the rate. Configuration registers are written on the plain port (i_cfg_we, i_cfg_idx,
// i_cfg_data); the user must write them only while the unit is idle, which the unit does
// not enforce. Indexes beyond the list are ignored. After reset the unit is ready at once.
`timescale 1ns / 1ps
`default_nettype none

module read_quality_filter_kmer_extract_unit #(
    parameter int MAX_CHUNK_LEN = rqf_pkg::MAX_CHUNK_LEN_DEF,
    parameter int MAX_KMER_LEN  = rqf_pkg::MAX_KMER_LEN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    rqf_in_if.sink                              i_in_ch,
    rqf_out_if.source                           o_out_ch,
    input  wire logic                           i_cfg_we,
    input  wire logic [rqf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rqf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers, held as one struct and shared by both parts.
    rqf_pkg::t_cfg   r_cfg;

    // Front-to-queue and queue-to-back links.
    logic            front_push;
    rqf_pkg::t_class front_item;
    logic            queue_space;
    logic            queue_valid;
    rqf_pkg::t_class queue_item;
    logic            back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kmer_len       <= rqf_pkg::KMER_LEN_RST;
            r_cfg.chunk_len      <= rqf_pkg::CHUNK_LEN_RST;
            r_cfg.reverse_strand <= rqf_pkg::REVERSE_RST;
            r_cfg.base_qual_min  <= rqf_pkg::BASE_QUAL_MIN_RST;
            r_cfg.avg_qual_min   <= rqf_pkg::AVG_QUAL_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rqf_pkg::CFG_KMER_LEN:       r_cfg.kmer_len       <= i_cfg_data[5:0];
                rqf_pkg::CFG_CHUNK_LEN:      r_cfg.chunk_len      <= i_cfg_data[8:0];
                rqf_pkg::CFG_REVERSE_STRAND: r_cfg.reverse_strand <= i_cfg_data[0];
                rqf_pkg::CFG_BASE_QUAL_MIN:  r_cfg.base_qual_min  <= i_cfg_data[6:0];
                rqf_pkg::CFG_AVG_QUAL_MIN:   r_cfg.avg_qual_min   <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // The front part decodes letters and qualities and steps the random code source
    // for letters other than ACGT, so the back part sees only small classified items.
    rqf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_ch),
        .i_cfg   (r_cfg),
        .i_space (queue_space),
        .o_push  (front_push),
        .o_item  (front_item)
    );

    // The queue lets the front keep accepting while the output side stalls briefly.
    rqf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_space (queue_space),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_pop   (back_pop)
    );

    // The back part holds the chunk state and the output register.
    rqf_back #(
        .MAX_CHUNK_LEN (MAX_CHUNK_LEN),
        .MAX_KMER_LEN  (MAX_KMER_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_pop   (back_pop),
        .o_out   (o_out_ch)
    );

endmodule

`default_nettype wire

FILE: src/rqf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "read_quality_filter_kmer_extract_unit_defines.svh"

// Port-level checks on the result channel.
module rqf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_kmer_valid,
    input wire logic [63:0] i_kmer_code,
    input wire logic        i_chunk_done,
    input wire logic        i_chunk_pass,
    input wire logic        i_chunk_dropped
);

    `RQF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kmer_code) && $stable(i_chunk_pass), "stalled result changed")
    `RQF_ASSERT_SAME(a_code_zero, i_out_valid && !i_kmer_valid, i_kmer_code == 64'd0, "k-mer code set without a valid k-mer")
    `RQF_ASSERT_SAME(a_no_empty, i_out_valid, i_kmer_valid || i_chunk_done || i_chunk_dropped, "result item carries no information")
    `RQF_ASSERT_SAME(a_pass_done, i_out_valid && i_chunk_pass, i_chunk_done && !i_chunk_dropped, "pass verdict outside a chunk end")

endmodule

bind read_quality_filter_kmer_extract_unit rqf_checker u_rqf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_ch.valid),
    .i_out_ready     (o_out_ch.ready),
    .i_kmer_valid    (o_out_ch.kmer_valid),
    .i_kmer_code     (o_out_ch.kmer_code),
    .i_chunk_done    (o_out_ch.chunk_done),
    .i_chunk_pass    (o_out_ch.chunk_pass),
    .i_chunk_dropped (o_out_ch.chunk_dropped)
);

`default_nettype wire
